// ===== src/midori128_block_cipher_assert.svh =====
// assertion macros shared by the midori128 checker
`ifndef MIDORI128_BLOCK_CIPHER_ASSERT_SVH
`define MIDORI128_BLOCK_CIPHER_ASSERT_SVH

// property checked only while out of reset
`define MC128_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define MC128_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/mc128_pkg.sv =====
// types, constant tables and round functions of the midori128 datapath
package mc128_pkg;

    // state bytes, byte 0 in the top bits
    typedef logic [0:15][7:0] state_t;

    // one request moving along the round chain
    typedef struct packed {
        logic   valid;
        logic   kind;
        state_t state;
    } stage_t;

    // configuration register indexes
    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    localparam int NUM_ROUNDS = 19;

    localparam logic [3:0] FWD_SHUFFLE [16] = '{
        4'd0, 4'd10, 4'd5, 4'd15, 4'd14, 4'd4, 4'd11, 4'd1,
        4'd9, 4'd3, 4'd12, 4'd6, 4'd7, 4'd13, 4'd2, 4'd8};

    localparam logic [3:0] INV_SHUFFLE [16] = '{
        4'd0, 4'd7, 4'd14, 4'd9, 4'd5, 4'd2, 4'd11, 4'd12,
        4'd15, 4'd8, 4'd1, 4'd6, 4'd10, 4'd13, 4'd4, 4'd3};

    localparam logic [2:0] BIT_PERM [4][8] = '{
        '{3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7},
        '{3'd1, 3'd6, 3'd7, 3'd0, 3'd5, 3'd2, 3'd3, 3'd4},
        '{3'd2, 3'd3, 3'd4, 3'd1, 3'd6, 3'd7, 3'd0, 3'd5},
        '{3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6}};

    localparam logic [3:0] NIB_BOX [16] = '{
        4'h1, 4'h0, 4'h5, 4'h3, 4'he, 4'h2, 4'hf, 4'h7,
        4'hd, 4'ha, 4'h9, 4'hb, 4'hc, 4'h8, 4'h4, 4'h6};

    // round constants, one bit per byte, byte 0 leftmost
    localparam logic [0:15] ROUND_CONST [NUM_ROUNDS] = '{
        16'b0001_0101_1011_0011, 16'b0111_1000_1100_0000,
        16'b1010_0100_0011_0101, 16'b0110_0010_0001_0011,
        16'b0001_0000_0100_1111, 16'b1101_0001_0111_0000,
        16'b0000_0010_0110_0110, 16'b0000_1011_1100_1100,
        16'b1001_0100_1000_0001, 16'b0100_0000_1011_1000,
        16'b0111_0001_1001_0111, 16'b0010_0010_1000_1110,
        16'b0101_0001_0011_0000, 16'b1111_1000_1100_1010,
        16'b1101_1111_1001_0000, 16'b0111_1100_1000_0001,
        16'b0001_1100_0010_0100, 16'b0010_0011_1011_0100,
        16'b0110_0010_1000_1010};

    // 8-bit box: bit permute, nibble boxes, inverse bit permute
    function automatic logic [7:0] byte_box(logic [7:0] x, logic [1:0] which);
        logic [7:0] mid;
        logic [7:0] sub;
        logic [7:0] res;
        mid = '0;
        res = '0;
        for (int k = 0; k < 8; k++) begin
            mid[3'(7 - k)] = x[3'd7 - BIT_PERM[which][k]];
        end
        sub = {NIB_BOX[mid[7:4]], NIB_BOX[mid[3:0]]};
        for (int k = 0; k < 8; k++) begin
            res[3'd7 - BIT_PERM[which][k]] = sub[3'(7 - k)];
        end
        return res;
    endfunction

    function automatic state_t sub_cells(state_t s);
        state_t r;
        for (int i = 0; i < 16; i++) begin
            r[i] = byte_box(s[i], 2'(i));
        end
        return r;
    endfunction

    function automatic state_t shuffle_fwd(state_t s);
        state_t r;
        for (int i = 0; i < 16; i++) begin
            r[i] = s[FWD_SHUFFLE[i]];
        end
        return r;
    endfunction

    function automatic state_t shuffle_inv(state_t s);
        state_t r;
        for (int i = 0; i < 16; i++) begin
            r[i] = s[INV_SHUFFLE[i]];
        end
        return r;
    endfunction

    // each byte becomes the xor of the other three of its column
    function automatic state_t mix_cols(state_t s);
        state_t     r;
        logic [7:0] sum;
        for (int c = 0; c < 4; c++) begin
            sum = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
            for (int j = 0; j < 4; j++) begin
                r[4*c+j] = sum ^ s[4*c+j];
            end
        end
        return r;
    endfunction

    // key with the round constant in each byte's lsb
    function automatic state_t add_const(state_t k, logic [0:15] rc);
        state_t r;
        for (int i = 0; i < 16; i++) begin
            r[i] = k[i] ^ {7'b0, rc[i]};
        end
        return r;
    endfunction

endpackage

// ===== src/mc128_round_cell.sv =====
// one round of the cipher chain, registered, with its own hold logic
module mc128_round_cell #(
    parameter int ROUND = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mc128_pkg::state_t   key_i,
    input  mc128_pkg::stage_t   up_i,
    output logic                up_ready_o,
    output mc128_pkg::stage_t   dn_o,
    input  logic                dn_ready_i
);
    import mc128_pkg::*;

    // encryption walks the constants upward, decryption downward
    localparam int ENC_IDX = ROUND - 1;
    localparam int DEC_IDX = NUM_ROUNDS - ROUND;

    logic   valid_reg;
    logic   kind_reg;
    state_t state_reg;
    state_t state_next;
    state_t sc;
    state_t enc_state;
    state_t dec_state;
    state_t dec_key;

    // round function on the incoming state
    always_comb begin
        sc        = sub_cells(up_i.state);
        enc_state = mix_cols(shuffle_fwd(sc)) ^ add_const(key_i, ROUND_CONST[ENC_IDX]);
        dec_key   = shuffle_inv(mix_cols(add_const(key_i, ROUND_CONST[DEC_IDX])));
        dec_state = shuffle_inv(mix_cols(sc)) ^ dec_key;
        state_next = up_i.kind ? dec_state : enc_state;
    end

    // take a new request when empty or when the next cell takes ours
    assign up_ready_o = !valid_reg || dn_ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready_o) begin
            valid_reg <= up_i.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (up_ready_o && up_i.valid) begin
            kind_reg  <= up_i.kind;
            state_reg <= state_next;
        end
    end

    assign dn_o = '{valid: valid_reg, kind: kind_reg, state: state_reg};

endmodule

// ===== src/midori128_block_cipher.sv =====
// midori128 cipher top level: key registers, round cell chain, output stage
//
// Input channel s_*: one 128-bit block per request, s_tuser selects the
// direction (0 encrypt, 1 decrypt). Output channel m_*: the 128-bit result.
// The key is written through cfg_we / cfg_index / cfg_data: index 0 is the
// high key half, index 1 the low half. Write the key only while no request
// is in flight.
// A request accepted at one clock edge passes through 19 round cells, each
// one register and the first loaded at the accepting edge, then the output
// register that does the final substitution and whitening. The input
// whitening sits in front of the first cell. A new block is taken every
// cycle while the chain does not stall; throughput is one block per clock,
// set by the one-round-per-cell chain.
// Every cell holds its request when the next one is full and stalled, so a
// stalled receiver fills the bubbles first and only then drops s_tready.
// Reset clears all valid flags and sets the key to zero.
module midori128_block_cipher (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
    input  logic         s_tuser,   // [0] kind
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] result_high, [127:64] result_low
);
    import mc128_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    state_t      key;
    stage_t      link [NUM_ROUNDS + 1];
    logic        rdy  [NUM_ROUNDS + 1];
    logic        m_valid_reg;
    state_t      m_state_reg;
    state_t      out_next;

    // key register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign key = {key_high_reg, key_low_reg};

    // input whitening in front of the first cell
    assign link[0]  = '{valid: s_tvalid, kind: s_tuser,
                        state: state_t'({s_tdata[63:0], s_tdata[127:64]}) ^ key};
    assign s_tready = rdy[0];

    // round cell chain
    for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
        mc128_round_cell #(
            .ROUND (r)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .key_i      (key),
            .up_i       (link[r-1]),
            .up_ready_o (rdy[r-1]),
            .dn_o       (link[r]),
            .dn_ready_i (rdy[r])
        );
    end

    // final substitution and whitening into the output register
    assign out_next         = sub_cells(link[NUM_ROUNDS].state) ^ key;
    assign rdy[NUM_ROUNDS]  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[NUM_ROUNDS]) begin
            m_valid_reg <= link[NUM_ROUNDS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NUM_ROUNDS] && link[NUM_ROUNDS].valid) begin
            m_state_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_state_reg[8:15], m_state_reg[0:7]};

endmodule

// ===== src/mc128_checker.sv =====
// port-level checks of the midori128 top level, bound to it
`include "midori128_block_cipher_assert.svh"

module mc128_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a result waiting on the receiver stays put
    `MC128_ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `MC128_ASSERT_RUN(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")

    // reset empties the chain
    `MC128_ASSERT_ALL(a_reset_empty, !aresetn |=> !m_tvalid, "result shown after reset")

    // an empty or draining output stage frees the whole chain
    `MC128_ASSERT_RUN(a_ready_free, !m_tvalid || m_tready |-> s_tready, "input blocked with free output")

endmodule

bind midori128_block_cipher mc128_checker u_mc128_checker (.*);

// ===== dv/midori128_block_cipher_tb.sv =====
// self-checking testbench for the midori128 block cipher stream engine
`timescale 1ns / 1ps

module midori128_block_cipher_tb;

    import mc128_pkg::cfg_reg_t;
    import mc128_pkg::REG_KEY_HIGH;
    import mc128_pkg::REG_KEY_LOW;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } direction_t;

    // cell i of the state is element i, cell 0 maps to the top byte of the high half
    typedef logic [15:0][7:0] cells_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } cipher_out_t;

    typedef struct packed {
        direction_t  dir;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } probe_t;

    localparam int MIDORI_ROUNDS   = 19;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int PHASE_COUNT     = 8;
    localparam int TAIL_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 400000;

    // nibble tables, entry n in bits [63-4n -: 4]
    localparam logic [63:0] FWD_ORDER = 64'h0A5F_E4B1_93C6_7D28;
    localparam logic [63:0] INV_ORDER = 64'h07E9_52BC_F816_AD43;
    localparam logic [63:0] NIB_SBOX  = 64'h1053_E2F7_DA9B_C846;

    // bit wiring around the nibble boxes, one row per cell position mod 4
    localparam int BIT_WIRE [4][8] = '{
        '{4, 1, 6, 3, 0, 5, 2, 7},
        '{1, 6, 7, 0, 5, 2, 3, 4},
        '{2, 3, 4, 1, 6, 7, 0, 5},
        '{7, 4, 1, 2, 3, 0, 5, 6}};

    // round constant bits, cell 0 in bit 15
    localparam logic [15:0] ROUND_BITS [MIDORI_ROUNDS] = '{
        16'h15B3, 16'h78C0, 16'hA435, 16'h6213, 16'h104F, 16'hD170, 16'h0266,
        16'h0BCC, 16'h9481, 16'h40B8, 16'h7197, 16'h228E, 16'h5130, 16'hF8CA,
        16'hDF90, 16'h7C81, 16'h1C24, 16'h23B4, 16'h628A};

    // directed blocks: zeros, ones, alternating bits and bytes, single bits, byte and nibble ramps
    localparam probe_t PROBES [12] = '{
        '{DIR_ENCRYPT, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
        '{DIR_DECRYPT, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
        '{DIR_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{DIR_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{DIR_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
        '{DIR_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
        '{DIR_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000},
        '{DIR_DECRYPT, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001},
        '{DIR_ENCRYPT, 64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F},
        '{DIR_DECRYPT, 64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F},
        '{DIR_ENCRYPT, 64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF},
        '{DIR_DECRYPT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}};

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = 1'b0;
    logic [63:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;   // [63:0] block_high, [127:64] block_low
    logic         s_tuser   = 1'b0; // [0] kind
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;          // [63:0] result_high, [127:64] result_low

    // key as the engine should hold it
    logic [63:0] key_high_cfg = '0;
    logic [63:0] key_low_cfg  = '0;

    cipher_out_t pending_results[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int blocks_sent    = 0;
    int decrypts_sent  = 0;
    int results_seen   = 0;
    int key_loads      = 0;
    int cycle_count    = 0;

    midori128_block_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [3:0] pick_nib(logic [63:0] tbl, int n);
        return tbl[63 - 4 * n -: 4];
    endfunction

    // one 8-bit box: rewire bits, nibble boxes, wire back
    function automatic logic [7:0] ssb(logic [7:0] x, int which);
        logic [7:0] mid;
        logic [7:0] sub;
        logic [7:0] res;
        mid = '0;
        res = '0;
        for (int k = 0; k < 8; k++) mid[7 - k] = x[7 - BIT_WIRE[which][k]];
        sub = {pick_nib(NIB_SBOX, int'(mid[7:4])), pick_nib(NIB_SBOX, int'(mid[3:0]))};
        for (int k = 0; k < 8; k++) res[7 - BIT_WIRE[which][k]] = sub[7 - k];
        return res;
    endfunction

    function automatic cells_t sub_layer(cells_t s);
        cells_t r;
        for (int i = 0; i < 16; i++) r[i] = ssb(s[i], i % 4);
        return r;
    endfunction

    function automatic cells_t reorder(cells_t s, logic [63:0] order);
        cells_t r;
        for (int i = 0; i < 16; i++) r[i] = s[pick_nib(order, i)];
        return r;
    endfunction

    function automatic cells_t column_mix(cells_t s);
        cells_t     r;
        logic [7:0] sum;
        for (int c = 0; c < 4; c++) begin
            sum = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
            for (int j = 0; j < 4; j++) r[4*c+j] = sum ^ s[4*c+j];
        end
        return r;
    endfunction

    function automatic cells_t to_cells(logic [63:0] hi, logic [63:0] lo);
        cells_t c;
        for (int j = 0; j < 8; j++) begin
            c[j]     = hi[63 - 8 * j -: 8];
            c[8 + j] = lo[63 - 8 * j -: 8];
        end
        return c;
    endfunction

    // full cipher in either direction under the current key
    function automatic cipher_out_t midori_transform(direction_t dir, logic [63:0] bh,
                                                     logic [63:0] bl);
        cells_t      st;
        cells_t      kc;
        cells_t      rk;
        int          rn;
        cipher_out_t o;
        kc = to_cells(key_high_cfg, key_low_cfg);
        st = to_cells(bh, bl) ^ kc;
        for (int r = 1; r <= MIDORI_ROUNDS; r++) begin
            rn = (dir == DIR_DECRYPT) ? MIDORI_ROUNDS + 1 - r : r;
            rk = kc;
            for (int i = 0; i < 16; i++) rk[i][0] = rk[i][0] ^ ROUND_BITS[rn - 1][15 - i];
            st = sub_layer(st);
            if (dir == DIR_DECRYPT) begin
                st = reorder(column_mix(st), INV_ORDER);
                rk = reorder(column_mix(rk), INV_ORDER);
            end else begin
                st = column_mix(reorder(st, FWD_ORDER));
            end
            st = st ^ rk;
        end
        st = sub_layer(st) ^ kc;
        o = '0;
        for (int j = 0; j < 8; j++) begin
            o.result_high = {o.result_high[55:0], st[j]};
            o.result_low  = {o.result_low[55:0], st[8 + j]};
        end
        return o;
    endfunction

    // half-block values biased toward the edges of the range
    function automatic logic [63:0] random_half();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            3: return ~(64'h1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // one request on the input stream, with random idle cycles in front
    task automatic push_block(direction_t dir, logic [63:0] bh, logic [63:0] bl,
                              output cipher_out_t want);
        want = midori_transform(dir, bh, bl);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
            s_tuser  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= dir;
        s_tdata  <= {bl, bh};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(want);
        blocks_sent++;
        if (dir == DIR_DECRYPT) decrypts_sent++;
    endtask

    // hold the input until every outstanding result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // write both key halves on back-to-back edges
    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_HIGH;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_index <= REG_KEY_LOW;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        key_high_cfg  = hi;
        key_low_cfg   = lo;
        key_loads++;
    endtask

    task automatic check_result(logic [63:0] got_hi, logic [63:0] got_lo);
        cipher_out_t want;
        if (pending_results.size() == 0) begin
            log_error($sformatf("result %h %h with no block outstanding", got_hi, got_lo));
        end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (got_hi !== want.result_high)
                log_error($sformatf("result_high exp %h got %h", want.result_high, got_hi));
            if (got_lo !== want.result_low)
                log_error($sformatf("result_low exp %h got %h", want.result_low, got_lo));
        end
    endtask

    // result side: compare each accepted result, random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata[63:0], m_tdata[127:64]);
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("midori128_block_cipher verification failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        direction_t  dir;
        direction_t  prev_dir;
        logic [63:0] bh;
        logic [63:0] bl;
        cipher_out_t last_out;

        prev_dir = DIR_ENCRYPT;
        last_out = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed blocks under the reset key, then under the all-ones key
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) load_key('1, '1);
            for (int i = 0; i < 12; i++)
                push_block(PROBES[i].dir, PROBES[i].block_high, PROBES[i].block_low,
                           last_out);
            wait_drained();
        end

        // random phases, a new key and pacing mode in each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: load_key('1, '0);
                1: load_key('0, '1);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // full pipeline flush in the middle of the second phase
                if (p == 1 && n == ITEMS_PER_PHASE / 2) wait_drained();
                // now and then feed a result back the other way
                if ($urandom_range(7) == 0) begin
                    dir = (prev_dir == DIR_ENCRYPT) ? DIR_DECRYPT : DIR_ENCRYPT;
                    bh  = last_out.result_high;
                    bl  = last_out.result_low;
                end else begin
                    dir = direction_t'($urandom_range(1));
                    bh  = random_half();
                    bl  = random_half();
                end
                push_block(dir, bh, bl, last_out);
                prev_dir = dir;
            end
            wait_drained();
        end

        // let any stray result show up
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            log_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("sent %0d blocks (%0d decrypt), checked %0d results under %0d keys",
                 blocks_sent, decrypts_sent, results_seen, key_loads + 1);
        $display("pacing: free flow, sparse sender, heavy backpressure, light jitter");
        if (error_count == 0) begin
            $display("midori128_block_cipher verification clean");
        end else begin
            $display("%0d errors", error_count);
            $display("midori128_block_cipher verification failed");
        end
        $finish;
    end

endmodule
